// ===== hdl/bmf_pkg.sv =====
`default_nettype none

package bmf_pkg;

   // Default sizing of the line store and the window.
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_RADIUS_DEF = 3;

   // Fixed field widths.
   localparam int PIX_W     = 8;
   localparam int POS_W     = 10;
   localparam int RAD_W     = 2;
   localparam int DIM_W     = 11;
   localparam int CSR_IDX_W = 2;

   // Register reset values and the fixed height limit.
   localparam logic [RAD_W-1:0] RADIUS_RST   = 2'd3;
   localparam logic [DIM_W-1:0] WIDTH_RST    = 11'd512;
   localparam logic [DIM_W-1:0] HEIGHT_RST   = 11'd512;
   localparam logic [DIM_W-1:0] HEIGHT_LIMIT = 11'd1024;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   // Division by the window area is a multiply by a rounded-up reciprocal.
   // With sums below 2^16 the product shifted right is the exact quotient.
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] rad);
      logic [RECIP_W-1:0] m;
      unique case (rad)
         2'd0: m = 25'd16777216;  // area 1
         2'd1: m = 25'd1864136;   // area 9
         2'd2: m = 25'd671089;    // area 25
         2'd3: m = 25'd342393;    // area 49
         default: m = 25'd16777216;
      endcase
      return m;
   endfunction

   // What travels with one pixel down the pipeline.
   typedef struct packed {
      logic             has_int;
      logic             has_bord;
      logic [RAD_W-1:0] rad;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic [PIX_W-1:0] pixel;
   } tag_type;

endpackage

`default_nettype wire

// ===== hdl/bmf_ram.sv =====
`default_nettype none

module bmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port; a read of the address being
   // written returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/bmf_line_col.sv =====
`default_nettype none

module bmf_line_col #(
   parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = bmf_pkg::MAX_RADIUS_DEF,
   localparam int NS  = 2 * MAX_RADIUS,
   localparam int SLW = $clog2(NS),
   localparam int CSW = bmf_pkg::PIX_W + $clog2(NS + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic             in_valid,
   input  wire bmf_pkg::tag_type in_tag,
   input  wire logic [SLW-1:0]   in_slot,
   output logic                  out_valid,
   output bmf_pkg::tag_type      out_tag,
   output logic [CSW-1:0]        out_colsum
);

   localparam int PW = bmf_pkg::PIX_W;
   localparam int WW = NS * PW;
   localparam int AW = $clog2(MAX_WIDTH);

   logic             s1_valid_ff, s1_valid_in;
   bmf_pkg::tag_type s1_tag_ff;
   logic [SLW-1:0]   s1_slot_ff;
   logic             fwd_ff, fwd_in;
   logic [WW-1:0]    fwd_word_ff;

   logic [WW-1:0]    rd_word;
   logic [WW-1:0]    word;
   logic [WW-1:0]    wr_word;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    wr_addr;
   logic             ram_we;
   logic [2:0]       span;
   logic [CSW-1:0]   colsum;

   // Each word holds one column of the stored rows, one lane per row slot.
   assign rd_addr = AW'(in_tag.col);
   assign wr_addr = AW'(s1_tag_ff.col);
   assign span    = {s1_tag_ff.rad, 1'b0};
   assign ram_we  = adv && s1_valid_ff && (span != 3'd0);

   bmf_ram #(
      .WIDTH (WW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // A write in the same cycle as the read of that column is forwarded.
   assign word = fwd_ff ? fwd_word_ff : rd_word;

   // Column sum over the active slots plus the new pixel, and the word with
   // the oldest row replaced by the new pixel.
   always_comb begin
      colsum  = CSW'(s1_tag_ff.pixel);
      wr_word = word;
      for (int s = 0; s < NS; s++) begin
         if (s < int'(span)) begin
            colsum = colsum + CSW'(word[s*PW +: PW]);
         end
         if (SLW'(s) == s1_slot_ff) begin
            wr_word[s*PW +: PW] = s1_tag_ff.pixel;
         end
      end
   end

   assign fwd_in      = ram_we && in_valid && (rd_addr == wr_addr);
   assign s1_valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff   <= in_tag;
         s1_slot_ff  <= in_slot;
         fwd_word_ff <= wr_word;
      end
   end

   assign out_valid  = s1_valid_ff;
   assign out_tag    = s1_tag_ff;
   assign out_colsum = colsum;

endmodule

`default_nettype wire

// ===== hdl/bmf_mean.sv =====
`default_nettype none

module bmf_mean #(
   parameter int MAX_RADIUS = bmf_pkg::MAX_RADIUS_DEF,
   localparam int WS  = 2 * MAX_RADIUS + 1,
   localparam int CSW = bmf_pkg::PIX_W + $clog2(WS)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic                        in_valid,
   input  wire bmf_pkg::tag_type            in_tag,
   input  wire logic [CSW-1:0]              in_colsum,
   output logic                             out_valid,
   output bmf_pkg::tag_type                 out_tag,
   output logic [bmf_pkg::PIX_W-1:0]        out_mean
);

   localparam int TW = bmf_pkg::PIX_W + $clog2(WS * WS);
   localparam int PRW = TW + bmf_pkg::RECIP_W;

   logic [CSW-1:0]   colsum_ff [WS];
   logic             s2_valid_ff, s3_valid_ff, s4_valid_ff;
   bmf_pkg::tag_type s2_tag_ff, s3_tag_ff, s4_tag_ff;
   logic [TW-1:0]    total_ff, total_in;
   logic [PRW-1:0]   prod_ff, prod_in;
   logic [2:0]       span;

   // Window of column sums: the newest column enters at the top end.
   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         for (int j = 0; j < WS - 1; j++) begin
            colsum_ff[j] <= colsum_ff[j+1];
         end
         colsum_ff[WS-1] <= in_colsum;
      end
   end

   // Add the newest 2*rad+1 column sums.
   assign span = {s2_tag_ff.rad, 1'b0};

   always_comb begin
      total_in = '0;
      for (int j = 0; j < WS; j++) begin
         if ((WS - 1 - j) <= int'(span)) begin
            total_in = total_in + TW'(colsum_ff[j]);
         end
      end
   end

   // Divide by the window area through its reciprocal.
   assign prod_in = PRW'(total_ff) * PRW'(bmf_pkg::recip(s3_tag_ff.rad));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= in_valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_tag_ff <= in_tag;
         s3_tag_ff <= s2_tag_ff;
         s4_tag_ff <= s3_tag_ff;
         total_ff  <= total_in;
         prod_ff   <= prod_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_tag   = s4_tag_ff;
   assign out_mean  = prod_ff[bmf_pkg::RECIP_SHIFT +: bmf_pkg::PIX_W];

endmodule

`default_nettype wire

// ===== hdl/box_mean_filter_2d_core.sv =====
// Path: line store stage, column window, total, product and output registers.
// Throughput: one pixel per cycle while rsp_ready is high, set by the single read
// and write port of the line store; a pixel that yields two results holds the
// input until its interior beat is taken.
// Reset: position counters and pipeline valid bits clear, registers return to
// radius 3 and a 512 by 512 frame; the line store is not cleared.
`default_nettype none

module box_mean_filter_2d_core #(
   parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = bmf_pkg::MAX_RADIUS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [bmf_pkg::PIX_W-1:0]       req_pixel,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [bmf_pkg::POS_W-1:0]            rsp_out_row,
   output logic [bmf_pkg::POS_W-1:0]            rsp_out_col,
   output logic [bmf_pkg::PIX_W-1:0]            rsp_out_pixel,
   output logic                                 rsp_last,
   input  wire logic                            csr_wr_en,
   input  wire logic [bmf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bmf_pkg::DIM_W-1:0]       csr_wdata
);

   localparam int NS  = 2 * MAX_RADIUS;
   localparam int SLW = $clog2(NS);
   localparam int WS  = 2 * MAX_RADIUS + 1;
   localparam int CSW = bmf_pkg::PIX_W + $clog2(WS);
   localparam int RW  = bmf_pkg::RAD_W;
   localparam int DW  = bmf_pkg::DIM_W;
   localparam int QW  = bmf_pkg::POS_W;
   localparam int WIDTH_LIMIT = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

   logic [RW-1:0]    radius_ff;
   logic [DW-1:0]    width_ff;
   logic [DW-1:0]    height_ff;
   logic [QW-1:0]    col_ff, col_in;
   logic [QW-1:0]    row_ff, row_in;
   logic [SLW-1:0]   slot_ff, slot_in;
   logic             o_int_ff, o_int_in;
   logic             o_bord_ff, o_bord_in;
   bmf_pkg::tag_type o_tag_ff;
   logic [bmf_pkg::PIX_W-1:0] o_mean_ff;

   logic [RW-1:0]    rad;
   logic [2:0]       span;
   logic [DW-1:0]    w_eff;
   logic [DW-1:0]    h_eff;
   logic             adv;
   logic             req_fire;
   logic             rsp_fire;
   logic             csr_hit;
   bmf_pkg::tag_type in_tag;
   logic             lc_valid;
   bmf_pkg::tag_type lc_tag;
   logic [CSW-1:0]   lc_colsum;
   logic             mn_valid;
   bmf_pkg::tag_type mn_tag;
   logic [bmf_pkg::PIX_W-1:0] mn_mean;

   // Configuration registers; a write to a known index restarts the frame.
   always_comb begin
      csr_hit = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            bmf_pkg::CSR_RADIUS,
            bmf_pkg::CSR_WIDTH,
            bmf_pkg::CSR_HEIGHT: csr_hit = 1'b1;
            default:             csr_hit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= bmf_pkg::RADIUS_RST;
         width_ff  <= bmf_pkg::WIDTH_RST;
         height_ff <= bmf_pkg::HEIGHT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bmf_pkg::CSR_RADIUS: radius_ff <= csr_wdata[RW-1:0];
            bmf_pkg::CSR_WIDTH:  width_ff  <= csr_wdata;
            bmf_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective settings after saturation.
   always_comb begin
      rad = radius_ff;
      if (int'(radius_ff) > MAX_RADIUS) begin
         rad = RW'(MAX_RADIUS);
      end
      span = {rad, 1'b0};

      w_eff = width_ff;
      if (width_ff == '0) begin
         w_eff = DW'(1);
      end else if (int'(width_ff) > WIDTH_LIMIT) begin
         w_eff = DW'(WIDTH_LIMIT);
      end

      h_eff = height_ff;
      if (height_ff == '0) begin
         h_eff = DW'(1);
      end else if (height_ff > bmf_pkg::HEIGHT_LIMIT) begin
         h_eff = bmf_pkg::HEIGHT_LIMIT;
      end
   end

   // The whole pipeline moves when the output register can take a new entry.
   assign adv       = !(o_int_ff || o_bord_ff) || (rsp_ready && (o_int_ff ^ o_bord_ff));
   assign req_ready = adv;
   assign req_fire  = req_valid && adv;
   assign rsp_valid = o_int_ff || o_bord_ff;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // Classify the arriving pixel from its position.
   always_comb begin
      in_tag.pixel    = req_pixel;
      in_tag.row      = row_ff;
      in_tag.col      = col_ff;
      in_tag.rad      = rad;
      in_tag.has_int  = (row_ff >= QW'(span)) && (col_ff >= QW'(span));
      in_tag.has_bord = (rad != '0) &&
                        ((row_ff < QW'(rad)) || (col_ff < QW'(rad)) ||
                         ((DW'(row_ff) + DW'(rad)) >= h_eff) ||
                         ((DW'(col_ff) + DW'(rad)) >= w_eff));
   end

   // Raster position and the line store slot of the current row.
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (csr_hit) begin
         col_in  = '0;
         row_in  = '0;
         slot_in = '0;
      end else if (req_fire) begin
         if ((DW'(col_ff) + DW'(1)) >= w_eff) begin
            col_in = '0;
            if ((DW'(row_ff) + DW'(1)) >= h_eff) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in = row_ff + QW'(1);
               if ((int'(slot_ff) + 1) >= int'(span)) begin
                  slot_in = '0;
               end else begin
                  slot_in = slot_ff + SLW'(1);
               end
            end
         end else begin
            col_in = col_ff + QW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   bmf_line_col #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_line_col (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_fire),
      .in_tag     (in_tag),
      .in_slot    (slot_ff),
      .out_valid  (lc_valid),
      .out_tag    (lc_tag),
      .out_colsum (lc_colsum)
   );

   bmf_mean #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_mean (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (lc_valid),
      .in_tag    (lc_tag),
      .in_colsum (lc_colsum),
      .out_valid (mn_valid),
      .out_tag   (mn_tag),
      .out_mean  (mn_mean)
   );

   // Output register: the interior beat goes out first, then the border beat.
   always_comb begin
      o_int_in  = o_int_ff;
      o_bord_in = o_bord_ff;
      if (adv) begin
         o_int_in  = mn_valid && mn_tag.has_int;
         o_bord_in = mn_valid && mn_tag.has_bord;
      end else if (rsp_fire) begin
         o_int_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_int_ff  <= 1'b0;
         o_bord_ff <= 1'b0;
      end else begin
         o_int_ff  <= o_int_in;
         o_bord_ff <= o_bord_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_tag_ff  <= mn_tag;
         o_mean_ff <= mn_mean;
      end
   end

   assign rsp_out_row   = o_int_ff ? (o_tag_ff.row - QW'(o_tag_ff.rad)) : o_tag_ff.row;
   assign rsp_out_col   = o_int_ff ? (o_tag_ff.col - QW'(o_tag_ff.rad)) : o_tag_ff.col;
   assign rsp_out_pixel = o_int_ff ? o_mean_ff : o_tag_ff.pixel;
   assign rsp_last      = !(o_int_ff && o_bord_ff);

endmodule

`default_nettype wire
